[src/hsv_pkg.sv]
`timescale 1ns / 1ps
// constants and types for the hsv to rgb converter
// no dependencies; used by the stream interfaces and the top level
package hsv_pkg;

    localparam int HUE_W = 15;
    localparam int CH_W  = 8;

    // one 60 degree sector in hue steps (6 fraction bits)
    localparam logic [11:0] SECT_STEPS  = 12'd3840;
    localparam logic [14:0] FULL_CIRCLE = 15'd23040;
    // 255 * 3840, full scale of a channel before the divide
    localparam logic [19:0] DENOM       = 20'd979200;
    // the divide by DENOM is a shift by 8 then a divide by 3825
    localparam logic [11:0] DIV_LO      = 12'd3825;
    // floor(2^32 / 3825)
    localparam logic [20:0] RECIP       = 21'd1122867;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    typedef logic [2:0][11:0] t_weight3;
    typedef logic [2:0][19:0] t_wide3;
    typedef logic [2:0][8:0]  t_est3;

endpackage

[src/hsv_stream_ifs.sv]
`timescale 1ns / 1ps
// valid/ready stream interfaces for hsv pixels in and rgb pixels out
// depends on hsv_pkg for the field widths
interface hsv_pix_if;
    logic                         valid;
    logic                         ready;
    logic [hsv_pkg::HUE_W-1:0]    hue;
    logic [hsv_pkg::CH_W-1:0]     saturation;
    logic [hsv_pkg::CH_W-1:0]     value;

    modport source (output valid, hue, saturation, value, input ready);
    modport sink   (input valid, hue, saturation, value, output ready);
endinterface

interface rgb_pix_if;
    logic                         valid;
    logic                         ready;
    logic [hsv_pkg::CH_W-1:0]     red;
    logic [hsv_pkg::CH_W-1:0]     green;
    logic [hsv_pkg::CH_W-1:0]     blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

[src/hsv_to_rgb_converter.sv]
`timescale 1ns / 1ps
// hsv to rgb converter, six register stages, one pixel per clock
// depends on hsv_pkg and the stream interfaces in hsv_stream_ifs.sv
// throughput: one pixel per cycle; the whole pipe holds while the output is stalled
// reset (synchronous, active low) clears the stage valid bits only
module hsv_to_rgb_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsv_pix_if.sink    i_pix,
    rgb_pix_if.source  o_pix
);

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_vld;
    logic            w_adv;

    // stage 1: hue wrap, sector, offset in sector
    hsv_pkg::t_sector r_sector, n_sector;
    logic [11:0]      r_f, n_f;
    logic [7:0]       r_s1, r_v1;
    // stage 2: per-channel weight 3840 - k
    hsv_pkg::t_weight3 r_d, n_d;
    logic [7:0]        r_s2, r_v2;
    // stage 3: 979200 - s*d
    hsv_pkg::t_wide3   r_t, n_t;
    logic [7:0]        r_v3;
    // stage 4: (v*t) >> 8
    hsv_pkg::t_wide3   r_x4, n_x4;
    // stage 5: reciprocal estimate of x / 3825
    hsv_pkg::t_wide3   r_x5;
    hsv_pkg::t_est3    r_est, n_est;
    // stage 6: corrected quotient
    logic [2:0][7:0]   r_q, n_q;
    logic [2:0][20:0]  w_rem;

    logic [14:0] w_hw;
    logic [14:0] w_base;
    logic [11:0] w_up;
    logic [27:0] w_p [3];
    logic [40:0] w_prod [3];

    assign w_adv       = !r_vld[NSTG-1] || o_pix.ready;
    assign i_pix.ready = w_adv;

    // stage 1
    always_comb begin
        w_hw = (i_pix.hue >= hsv_pkg::FULL_CIRCLE) ?
               i_pix.hue - hsv_pkg::FULL_CIRCLE : i_pix.hue;
        if (w_hw < 15'd3840) begin
            n_sector = hsv_pkg::SEC_R_TO_Y;
            w_base   = 15'd0;
        end else if (w_hw < 15'd7680) begin
            n_sector = hsv_pkg::SEC_Y_TO_G;
            w_base   = 15'd3840;
        end else if (w_hw < 15'd11520) begin
            n_sector = hsv_pkg::SEC_G_TO_C;
            w_base   = 15'd7680;
        end else if (w_hw < 15'd15360) begin
            n_sector = hsv_pkg::SEC_C_TO_B;
            w_base   = 15'd11520;
        end else if (w_hw < 15'd19200) begin
            n_sector = hsv_pkg::SEC_B_TO_M;
            w_base   = 15'd15360;
        end else begin
            n_sector = hsv_pkg::SEC_M_TO_R;
            w_base   = 15'd19200;
        end
        n_f = 12'(w_hw - w_base);
    end

    // stage 2: chroma gets 0, zero gets 3840, rising x gets 3840-f, falling x gets f
    always_comb begin
        w_up = hsv_pkg::SECT_STEPS - r_f;
        case (r_sector)
            hsv_pkg::SEC_R_TO_Y: n_d = {hsv_pkg::SECT_STEPS, w_up, 12'd0};
            hsv_pkg::SEC_Y_TO_G: n_d = {hsv_pkg::SECT_STEPS, 12'd0, r_f};
            hsv_pkg::SEC_G_TO_C: n_d = {w_up, 12'd0, hsv_pkg::SECT_STEPS};
            hsv_pkg::SEC_C_TO_B: n_d = {12'd0, r_f, hsv_pkg::SECT_STEPS};
            hsv_pkg::SEC_B_TO_M: n_d = {12'd0, hsv_pkg::SECT_STEPS, w_up};
            default:             n_d = {r_f, hsv_pkg::SECT_STEPS, 12'd0};
        endcase
    end

    // stages 3 to 6, one lane per channel
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_t[c]    = hsv_pkg::DENOM - (20'(r_s2) * 20'(r_d[c]));
            w_p[c]    = 28'(r_v3) * 28'(r_t[c]);
            n_x4[c]   = w_p[c][27:8];
            w_prod[c] = 41'(r_x4[c]) * 41'(hsv_pkg::RECIP);
            n_est[c]  = w_prod[c][40:32];
            // estimate is the true quotient or one short of it
            w_rem[c]  = 21'(r_x5[c]) - (21'(r_est[c]) * 21'(hsv_pkg::DIV_LO));
            n_q[c]    = (w_rem[c] >= 21'(hsv_pkg::DIV_LO)) ?
                        8'(r_est[c] + 9'd1) : r_est[c][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_pix.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sector <= n_sector;
            r_f      <= n_f;
            r_s1     <= i_pix.saturation;
            r_v1     <= i_pix.value;
            r_d      <= n_d;
            r_s2     <= r_s1;
            r_v2     <= r_v1;
            r_t      <= n_t;
            r_v3     <= r_v2;
            r_x4     <= n_x4;
            r_x5     <= r_x4;
            r_est    <= n_est;
            r_q      <= n_q;
        end
    end

    assign o_pix.valid = r_vld[NSTG-1];
    assign o_pix.red   = r_q[0];
    assign o_pix.green = r_q[1];
    assign o_pix.blue  = r_q[2];

    a_f_in_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r_f < hsv_pkg::SECT_STEPS)
        else $error("hue offset outside its sector");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_d[0] <= hsv_pkg::SECT_STEPS && r_d[1] <= hsv_pkg::SECT_STEPS
                      && r_d[2] <= hsv_pkg::SECT_STEPS))
        else $error("channel weight above one sector");

    a_est_one_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (w_rem[0] < 21'd7650 && w_rem[1] < 21'd7650 && w_rem[2] < 21'd7650))
        else $error("reciprocal estimate off by more than one");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld) && $stable(r_q))
        else $error("pipeline moved during output stall");

endmodule
